### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they use the clk and rst_n of the
// enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        KIND_TRACE = 1'b0,
        KIND_FINAL = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

### sv/pfe_if.sv
// ----------------------------------------------------------------------------
// pfe channel interfaces
// Valid/ready channels for input characters and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expr;

    modport source (output valid, output char_code, output end_of_expr, input ready);
    modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfe_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] left_operand;
    logic [1:0]         operator_code;
    logic signed [31:0] right_operand;
    logic signed [31:0] value;
    logic               underflow;
    logic               divide_by_zero;
    logic               overflow_seen;

    modport source (output valid, output result_kind, output left_operand,
                    output operator_code, output right_operand, output value,
                    output underflow, output divide_by_zero, output overflow_seen,
                    input ready);
    modport sink   (input valid, input result_kind, input left_operand,
                    input operator_code, input right_operand, input value,
                    input underflow, input divide_by_zero, input overflow_seen,
                    output ready);
endinterface

`default_nettype wire

### sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// Signed truncating divider, one quotient bit per cycle on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [pfe_pkg::DATA_W-1:0] dividend,
    input  wire logic signed [pfe_pkg::DATA_W-1:0] divisor,
    output      logic                           done,
    output      logic signed [pfe_pkg::DATA_W-1:0] quotient
);
    import pfe_pkg::*;

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] divs_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        diff    = shifted - {1'b0, divs_reg};
        fits    = !diff[DATA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DATA_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend[DATA_W-1] ? (-dividend) : dividend;
            divs_reg <= divisor[DATA_W-1] ? (-divisor) : divisor;
            rem_reg  <= '0;
            neg_reg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (-quo_reg) : quo_reg;

endmodule

`default_nettype wire

### sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// RPN calculator: digits push, + - * / combine the two top entries, an end
// item pops the final value and clears the stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  cmd     | in  | char_code, end_of_expr
//  res     | out | result_kind, left/right_operand, operator_code, value, flags
//
//  Digits and ignored characters are taken in S_IDLE; an end item passes through
//  S_FIN to S_OUT for the output transfer; + - * and a divide by zero pass through
//  S_POP_R, S_POP_L and S_EXEC to S_OUT. A nonzero divide also waits in S_DIV for
//  the one-bit-per-cycle divider. Each pop goes through one registered RAM read.
//  Reset clears the stack count and the sticky overflow flag; no clearing pass.
//  The block holds cmd.ready low until a waiting result has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    pfe_cmd_if.sink   cmd,
    pfe_res_if.source res
);
    import pfe_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              sticky_reg, sticky_next;

    op_t               op_reg, op_next;
    kind_t             kind_reg, kind_next;
    logic [DATA_W-1:0] left_reg, left_next;
    logic [DATA_W-1:0] right_reg, right_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              under_reg, under_next;
    logic              dz_reg, dz_next;
    logic              ovf_reg, ovf_next;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    op_t               dec_op;
    logic [7:0]        digit;
    logic              full;
    logic              empty;
    logic              div_go;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [CNT_W-1:0]  rd_ptr;

    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    // ---------------- decode ----------------
    always_comb
    begin
        is_digit = cmd.char_code inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = cmd.char_code - CHAR_ZERO;
        is_op    = 1'b1;
        dec_op   = OP_ADD;
        case (cmd.char_code)
            CHAR_PLUS:  dec_op = OP_ADD;
            CHAR_MINUS: dec_op = OP_SUB;
            CHAR_STAR:  dec_op = OP_MUL;
            CHAR_SLASH: dec_op = OP_DIV;
            default:    is_op  = 1'b0;
        endcase
    end

    assign full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty  = (count_reg == '0);
    assign accept = cmd.valid && cmd.ready;
    assign div_go = (state_reg == S_EXEC) && (op_reg == OP_DIV) && (right_reg != '0);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.end_of_expr)
                        state_next = S_FIN;
                    else if (is_op)
                        state_next = S_POP_R;
                end
            end
            S_POP_R: state_next = S_POP_L;
            S_POP_L: state_next = S_EXEC;
            S_EXEC:  state_next = div_go ? S_DIV : S_OUT;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_FIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (res.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        count_next  = count_reg;
        sticky_next = sticky_reg;
        op_next     = op_reg;
        kind_next   = kind_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        value_next  = value_reg;
        under_next  = under_reg;
        dz_next     = dz_reg;
        ovf_next    = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !cmd.end_of_expr)
                begin
                    if (is_digit)
                    begin
                        if (full)
                            sticky_next = 1'b1;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                    else if (is_op)
                    begin
                        op_next    = dec_op;
                        kind_next  = KIND_TRACE;
                        under_next = 1'b0;
                        dz_next    = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            S_POP_R:
            begin
                right_next = empty ? '0 : ram_rdata;
                under_next = under_reg | empty;
                if (!empty)
                    count_next = count_reg - CNT_W'(1);
            end
            S_POP_L:
            begin
                left_next  = empty ? '0 : ram_rdata;
                under_next = under_reg | empty;
                if (!empty)
                    count_next = count_reg - CNT_W'(1);
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD:  value_next = left_reg + right_reg;
                    OP_SUB:  value_next = left_reg - right_reg;
                    OP_MUL:  value_next = left_reg * right_reg;
                    OP_DIV:
                    begin
                        value_next = '0;
                        dz_next    = (right_reg == '0);
                    end
                    default: value_next = '0;
                endcase
                // two pops always leave room for the result
                if (!div_go)
                    count_next = count_reg + CNT_W'(1);
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    value_next = div_quo;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_FIN:
            begin
                kind_next   = KIND_FINAL;
                op_next     = OP_ADD;
                left_next   = '0;
                right_next  = '0;
                dz_next     = 1'b0;
                value_next  = empty ? '0 : ram_rdata;
                under_next  = empty;
                ovf_next    = sticky_reg;
                count_next  = '0;
                sticky_next = 1'b0;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // ---------------- outputs and RAM control ----------------
    always_comb
    begin
        cmd.ready = (state_reg == S_IDLE);
        res.valid = (state_reg == S_OUT);
        ram_we    = 1'b0;
        ram_wdata = value_next;
        case (state_reg)
            S_IDLE:
            begin
                ram_we    = accept && !cmd.end_of_expr && is_digit && !full;
                ram_wdata = DATA_W'(digit[3:0]);
            end
            S_EXEC:  ram_we = !div_go;
            S_DIV:   ram_we = div_done;
            default: ram_we = 1'b0;
        endcase
    end

    // read the entry that will be on top after this cycle
    assign rd_ptr    = count_next - CNT_W'(1);
    assign ram_raddr = rd_ptr[ADDR_W-1:0];
    assign ram_waddr = count_reg[ADDR_W-1:0];

    assign res.result_kind    = kind_reg;
    assign res.left_operand   = left_reg;
    assign res.operator_code  = op_reg;
    assign res.right_operand  = right_reg;
    assign res.value          = value_reg;
    assign res.underflow      = under_reg;
    assign res.divide_by_zero = dz_reg;
    assign res.overflow_seen  = ovf_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        kind_reg  <= kind_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        value_reg <= value_next;
        under_reg <= under_next;
        dz_reg    <= dz_next;
        ovf_reg   <= ovf_next;
    end

    // ---------------- units ----------------
    pfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (left_reg),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(STACK_DEPTH), "stack count past depth")
    `ASSERT_IMP(a_write_room, ram_we, count_reg < CNT_W'(STACK_DEPTH), "push into full stack")
    `ASSERT_NXT(a_end_clears, state_reg == S_FIN, count_reg == '0 && !sticky_reg,
                "end item did not clear stack")
    `ASSERT_IMP(a_final_fields, res.valid && res.result_kind,
                res.left_operand == '0 && res.right_operand == '0 && !res.divide_by_zero,
                "final result carries operation fields")

endmodule

`default_nettype wire
